/* rtl/core/ucpd_pkg.sv */
// ----------------------------------------------------------------------------
// ucpd_pkg: shared types and constants of the UART command packet deframer
// Payload structs, status and command codes, buffer sizing and the FSM type.
// ----------------------------------------------------------------------------
package ucpd_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    localparam logic [7:0]  SYNC0       = 8'hAA;
    localparam logic [7:0]  SYNC1       = 8'hBB;
    localparam logic [7:0]  LEN_MIN     = 8'd4;
    localparam logic [7:0]  LEN_MAX     = 8'(BUF_DEPTH);
    localparam logic [15:0] TIMEOUT_RST = 16'd1500;
    localparam logic [7:0]  PAGE_RST    = 8'd2;

    // byte positions inside a frame
    localparam logic [CNT_W-1:0] POS_SYNC0 = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_SYNC1 = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_LEN   = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_CMD   = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_PAGE  = CNT_W'(4);
    localparam logic [CNT_W-1:0] LEN_PAGE  = CNT_W'(5);
    localparam logic [CNT_W-1:0] LEN_TEXT  = CNT_W'(6);
    localparam logic [ADDR_W-1:0] PAY_START = ADDR_W'(4);

    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_HDR_ERR = 3'd1;
    localparam logic [2:0] ST_SUM_ERR = 3'd2;
    localparam logic [2:0] ST_ACCEPT  = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;

    localparam logic [7:0] CMD_AUTO   = 8'd0;
    localparam logic [7:0] CMD_MANUAL = 8'd1;
    localparam logic [7:0] CMD_TEXT1  = 8'd2;
    localparam logic [7:0] CMD_TEXT2  = 8'd3;

    localparam logic KIND_BYTE = 1'b0;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] command;
        logic       auto_mode_flag;
        logic [7:0] page_select;
        logic       refresh_request;
        logic       text_valid;
        logic       text_line;
        logic [7:0] text_byte;
        logic       last;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

endpackage

/* rtl/core/ucpd_ram.sv */
// ----------------------------------------------------------------------------
// ucpd_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module ucpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/uart_command_packet_deframer_unit.sv */
// ----------------------------------------------------------------------------
// uart_command_packet_deframer_unit: UART command packet deframer
// Frames AA BB len cmd payload sum packets and reports mode and text results.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_data) carries one received
//    byte or one millisecond tick per transaction.
//  - Output channel (o_out_valid / i_out_stall / o_out_data) carries results.
//    Every input gives one result, except an accepted text packet with a
//    payload, which gives one result per payload byte, the final one marked.
//  - i_cfg_we / i_cfg_data write the timeout in ticks; write while idle.
//  - Timing: a single result is registered at the edge that accepts its
//    input. The output register must empty before the next transaction is
//    accepted, so no new item is taken while a result is held.
//  - Text payload is read back from the packet RAM byte by byte (read issue,
//    then load of the output register once it is empty), starting after the sum
//    byte; input stays stalled until the last text byte is loaded.
//  - A stall on the output holds the result and, through it, the input.
//  - Reset: empty frame, auto mode on, page 2, timeout 1500. The packet RAM
//    is not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module uart_command_packet_deframer_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ucpd_pkg::t_item   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ucpd_pkg::t_result o_out_data,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data
);

    ucpd_pkg::t_state  r_state, n_state;
    ucpd_pkg::t_result r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [ucpd_pkg::CNT_W-1:0]  r_byte_cnt, n_byte_cnt;
    logic [ucpd_pkg::CNT_W-1:0]  r_exp_len, n_exp_len;
    logic                        r_frame_open, n_frame_open;
    logic [15:0]                 r_idle, n_idle;
    logic                        r_auto, n_auto;
    logic [7:0]                  r_page, n_page;
    logic [15:0]                 r_timeout;
    logic [7:0]                  r_sum, n_sum;
    logic [7:0]                  r_hdr0, n_hdr0;
    logic [7:0]                  r_hdr1, n_hdr1;
    logic [7:0]                  r_len, n_len;
    logic [7:0]                  r_cmd, n_cmd;
    logic [7:0]                  r_b4, n_b4;
    logic [ucpd_pkg::ADDR_W-1:0] r_rd_addr, n_rd_addr;
    logic [ucpd_pkg::ADDR_W-1:0] r_end_addr, n_end_addr;
    logic                        r_line, n_line;

    logic                        w_accept;
    logic [7:0]                  w_b;
    logic [15:0]                 w_idle_inc;
    logic                        w_hdr_chk;
    logic                        w_hdr_ok;
    logic                        w_open_now;
    logic [ucpd_pkg::CNT_W-1:0]  w_exp_now;
    logic                        w_store_en;
    logic [ucpd_pkg::CNT_W-1:0]  w_cnt_inc;
    logic                        w_complete;
    logic [7:0]                  w_cur_cmd;
    logic [7:0]                  w_cur_b4;
    logic                        w_cur_line;
    logic                        w_ram_we;
    logic                        w_ram_re;
    logic [7:0]                  w_ram_rdata;

    assign o_in_stall  = (r_state != ucpd_pkg::S_IDLE) || r_out_valid;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_b        = i_in_data.rx_byte;
    assign w_idle_inc = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
    assign w_hdr_chk  = (r_byte_cnt == ucpd_pkg::POS_CMD) && !r_frame_open;
    assign w_hdr_ok   = (r_hdr0 == ucpd_pkg::SYNC0) && (r_hdr1 == ucpd_pkg::SYNC1) &&
                        (r_len >= ucpd_pkg::LEN_MIN) && (r_len <= ucpd_pkg::LEN_MAX);
    assign w_open_now = r_frame_open || (w_hdr_chk && w_hdr_ok);
    // length is range checked before the frame opens, so the cut is lossless
    assign w_exp_now  = r_frame_open ? r_exp_len : ucpd_pkg::CNT_W'(r_len);
    assign w_store_en = r_byte_cnt < ucpd_pkg::CNT_W'(ucpd_pkg::BUF_DEPTH);
    assign w_cnt_inc  = w_store_en ? r_byte_cnt + ucpd_pkg::CNT_W'(1) : r_byte_cnt;
    assign w_complete = w_open_now && (w_cnt_inc == w_exp_now);
    // command and page bytes may be the byte arriving right now
    assign w_cur_cmd  = (r_byte_cnt == ucpd_pkg::POS_CMD) ? w_b : r_cmd;
    assign w_cur_b4   = (r_byte_cnt == ucpd_pkg::POS_PAGE) ? w_b : r_b4;
    assign w_cur_line = (w_cur_cmd == ucpd_pkg::CMD_TEXT2);

    ucpd_ram #(
        .WIDTH (8),
        .DEPTH (ucpd_pkg::BUF_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_byte_cnt[ucpd_pkg::ADDR_W-1:0]),
        .i_wdata (w_b),
        .i_re    (w_ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_byte_cnt   = r_byte_cnt;
        n_exp_len    = r_exp_len;
        n_frame_open = r_frame_open;
        n_idle       = r_idle;
        n_auto       = r_auto;
        n_page       = r_page;
        n_sum        = r_sum;
        n_hdr0       = r_hdr0;
        n_hdr1       = r_hdr1;
        n_len        = r_len;
        n_cmd        = r_cmd;
        n_b4         = r_b4;
        n_rd_addr    = r_rd_addr;
        n_end_addr   = r_end_addr;
        n_line       = r_line;
        w_ram_we     = 1'b0;
        w_ram_re     = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ucpd_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    if (i_in_data.kind != ucpd_pkg::KIND_BYTE) begin
                        n_idle = w_idle_inc;
                        if (r_frame_open && (w_idle_inc > r_timeout)) begin
                            n_frame_open = 1'b0;
                            n_exp_len    = '0;
                            n_byte_cnt   = '0;
                            n_sum        = '0;
                            n_out.status = ucpd_pkg::ST_TIMEOUT;
                        end
                    end else begin
                        n_idle = '0;
                        if (w_hdr_chk && !w_hdr_ok) begin
                            // drop the fourth byte and restart
                            n_byte_cnt   = '0;
                            n_exp_len    = '0;
                            n_sum        = '0;
                            n_out.status = ucpd_pkg::ST_HDR_ERR;
                        end else begin
                            w_ram_we = w_store_en;
                            unique case (r_byte_cnt)
                                ucpd_pkg::POS_SYNC0: n_hdr0 = w_b;
                                ucpd_pkg::POS_SYNC1: n_hdr1 = w_b;
                                ucpd_pkg::POS_LEN:   n_len  = w_b;
                                ucpd_pkg::POS_CMD:   n_cmd  = w_b;
                                ucpd_pkg::POS_PAGE:  n_b4   = w_b;
                                default: ;
                            endcase
                            n_byte_cnt   = w_cnt_inc;
                            n_frame_open = w_open_now;
                            n_exp_len    = w_exp_now;
                            n_sum        = r_sum + w_b;
                            if (w_complete) begin
                                n_frame_open = 1'b0;
                                n_exp_len    = '0;
                                n_byte_cnt   = '0;
                                n_sum        = '0;
                                if (r_sum != w_b) begin
                                    n_out.status = ucpd_pkg::ST_SUM_ERR;
                                end else begin
                                    n_out.status  = ucpd_pkg::ST_ACCEPT;
                                    n_out.command = w_cur_cmd;
                                    priority if (w_cur_cmd == ucpd_pkg::CMD_AUTO) begin
                                        n_auto = 1'b1;
                                        n_page = (w_exp_now >= ucpd_pkg::LEN_PAGE) ?
                                                 w_cur_b4 : 8'd0;
                                        n_out.refresh_request = 1'b1;
                                    end else if (w_cur_cmd == ucpd_pkg::CMD_MANUAL) begin
                                        n_auto = 1'b0;
                                    end else if (w_cur_cmd == ucpd_pkg::CMD_TEXT1 ||
                                                 w_cur_cmd == ucpd_pkg::CMD_TEXT2) begin
                                        n_auto                = 1'b0;
                                        n_out.refresh_request = w_cur_line;
                                        n_out.text_line       = w_cur_line;
                                        if (w_exp_now >= ucpd_pkg::LEN_TEXT) begin
                                            // hand off to the RAM walk over the payload
                                            n_out_valid = 1'b0;
                                            n_rd_addr   = ucpd_pkg::PAY_START;
                                            n_end_addr  = ucpd_pkg::ADDR_W'(w_exp_now -
                                                          ucpd_pkg::CNT_W'(2));
                                            n_line      = w_cur_line;
                                            n_state     = ucpd_pkg::S_READ;
                                        end
                                    end else begin
                                        // unknown command: report only
                                    end
                                end
                            end
                        end
                    end
                    n_out.auto_mode_flag = n_auto;
                    n_out.page_select    = n_page;
                end
            end
            ucpd_pkg::S_READ: begin
                w_ram_re = 1'b1;
                n_state  = ucpd_pkg::S_EMIT;
            end
            ucpd_pkg::S_EMIT: begin
                if (!r_out_valid) begin
                    n_out_valid           = 1'b1;
                    n_out.status          = ucpd_pkg::ST_ACCEPT;
                    n_out.command         = r_line ? ucpd_pkg::CMD_TEXT2 : ucpd_pkg::CMD_TEXT1;
                    n_out.auto_mode_flag  = r_auto;
                    n_out.page_select     = r_page;
                    n_out.refresh_request = r_line;
                    n_out.text_valid      = 1'b1;
                    n_out.text_line       = r_line;
                    n_out.text_byte       = w_ram_rdata;
                    n_out.last            = (r_rd_addr == r_end_addr);
                    if (r_rd_addr == r_end_addr) begin
                        n_state = ucpd_pkg::S_IDLE;
                    end else begin
                        n_rd_addr = r_rd_addr + ucpd_pkg::ADDR_W'(1);
                        n_state   = ucpd_pkg::S_READ;
                    end
                end
            end
            default: n_state = ucpd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ucpd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_byte_cnt   <= '0;
            r_exp_len    <= '0;
            r_frame_open <= 1'b0;
            r_idle       <= '0;
            r_auto       <= 1'b1;
            r_page       <= ucpd_pkg::PAGE_RST;
            r_sum        <= '0;
            r_timeout    <= ucpd_pkg::TIMEOUT_RST;
        end else begin
            r_out_valid  <= n_out_valid;
            r_byte_cnt   <= n_byte_cnt;
            r_exp_len    <= n_exp_len;
            r_frame_open <= n_frame_open;
            r_idle       <= n_idle;
            r_auto       <= n_auto;
            r_page       <= n_page;
            r_sum        <= n_sum;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_hdr0     <= n_hdr0;
        r_hdr1     <= n_hdr1;
        r_len      <= n_len;
        r_cmd      <= n_cmd;
        r_b4       <= n_b4;
        r_rd_addr  <= n_rd_addr;
        r_end_addr <= n_end_addr;
        r_line     <= n_line;
    end

    a_write_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == ucpd_pkg::S_IDLE) && w_accept)
        else $error("packet RAM written outside an accepted byte");

    a_closed_frame_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_frame_open |-> (r_byte_cnt <= ucpd_pkg::POS_CMD))
        else $error("closed frame holds more than the header bytes");

    a_open_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_open |-> (r_byte_cnt < r_exp_len))
        else $error("open frame count reached its length");

    a_emit_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ucpd_pkg::S_READ) |=> (r_state == ucpd_pkg::S_EMIT))
        else $error("RAM read not followed by emit");

endmodule

/* test/uart_command_packet_deframer_unit_test.sv */
// ----------------------------------------------------------------------------
// uart_command_packet_deframer_unit_test: self-checking bench for the deframer
// Drives bytes and ticks through the input channel and tracks frame state,
// mode, page and text output in a local copy of the deframer. Every output
// transaction is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module uart_command_packet_deframer_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic        KIND_TICK   = ~ucpd_pkg::KIND_BYTE;
    localparam int          HOLD_CYCLES = 400;
    localparam int unsigned STALL_LIMIT = 4000;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    ucpd_pkg::t_item   i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    ucpd_pkg::t_result o_out_data;
    logic              i_cfg_we    = 1'b0;
    logic [15:0]       i_cfg_data  = '0;

    uart_command_packet_deframer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // local copy of the deframer state
    logic [7:0]  frame_bytes [ucpd_pkg::BUF_DEPTH];
    int          byte_count;
    int          expected_len;
    bit          frame_open;
    logic [15:0] idle_ticks;
    bit          auto_on;
    logic [7:0]  page_sel;
    logic [15:0] timeout_ticks;

    ucpd_pkg::t_result frame_results [$];
    int                mismatches;

    int          send_idle_pct;
    int          stall_pct;
    int unsigned hold_requests;
    int unsigned hold_served;
    int          hold_left;

    // ------------------------------------------------------------------------
    // deframer state tracking
    // ------------------------------------------------------------------------
    function automatic void clear_frame();
        frame_open   = 1'b0;
        expected_len = 0;
        byte_count   = 0;
    endfunction

    function automatic void push_result(logic [2:0] status, logic [7:0] cmd, logic refresh,
                                        logic tv, logic line, logic [7:0] tb, logic fin);
        ucpd_pkg::t_result r;
        r.status          = status;
        r.command         = cmd;
        r.auto_mode_flag  = auto_on;
        r.page_select     = page_sel;
        r.refresh_request = refresh;
        r.text_valid      = tv;
        r.text_line       = line;
        r.text_byte       = tb;
        r.last            = fin;
        frame_results.push_back(r);
    endfunction

    task automatic deframe_step(input ucpd_pkg::t_item it);
        int         len;
        int         n;
        logic [7:0] sum;
        logic [7:0] cmd;
        logic       line;
        if (it.kind != ucpd_pkg::KIND_BYTE) begin
            if (idle_ticks != 16'hFFFF)
                idle_ticks++;
            if (frame_open && idle_ticks > timeout_ticks) begin
                clear_frame();
                push_result(ucpd_pkg::ST_TIMEOUT, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
            end else begin
                push_result(ucpd_pkg::ST_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
            end
            return;
        end
        idle_ticks = '0;
        // header check falls on the fourth byte; drop it on error
        if (byte_count == 3 && !frame_open) begin
            len = int'(frame_bytes[2]);
            if (frame_bytes[0] == ucpd_pkg::SYNC0 && frame_bytes[1] == ucpd_pkg::SYNC1 &&
                len >= int'(ucpd_pkg::LEN_MIN) && len <= ucpd_pkg::BUF_DEPTH) begin
                frame_open   = 1'b1;
                expected_len = len;
            end else begin
                clear_frame();
                push_result(ucpd_pkg::ST_HDR_ERR, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
                return;
            end
        end
        if (byte_count < ucpd_pkg::BUF_DEPTH) begin
            frame_bytes[byte_count] = it.rx_byte;
            byte_count++;
        end
        if (!(frame_open && byte_count == expected_len)) begin
            push_result(ucpd_pkg::ST_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
            return;
        end
        len = expected_len;
        clear_frame();
        sum = 8'h00;
        for (int i = 0; i < len - 1; i++)
            sum = sum + frame_bytes[i];
        if (sum != frame_bytes[len-1]) begin
            push_result(ucpd_pkg::ST_SUM_ERR, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
            return;
        end
        cmd = frame_bytes[3];
        case (cmd)
            ucpd_pkg::CMD_AUTO: begin
                auto_on  = 1'b1;
                page_sel = (len >= 5) ? frame_bytes[4] : 8'h00;
                push_result(ucpd_pkg::ST_ACCEPT, cmd, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1);
            end
            ucpd_pkg::CMD_MANUAL: begin
                auto_on = 1'b0;
                push_result(ucpd_pkg::ST_ACCEPT, cmd, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
            end
            ucpd_pkg::CMD_TEXT1, ucpd_pkg::CMD_TEXT2: begin
                line    = (cmd == ucpd_pkg::CMD_TEXT2);
                auto_on = 1'b0;
                n       = (len >= 6) ? len - 5 : 0;
                if (n == 0) begin
                    push_result(ucpd_pkg::ST_ACCEPT, cmd, line, 1'b0, line, 8'h00, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        push_result(ucpd_pkg::ST_ACCEPT, cmd, line, 1'b1, line,
                                    frame_bytes[4+i], (i == n - 1));
                end
            end
            default: begin
                push_result(ucpd_pkg::ST_ACCEPT, cmd, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stall, plus long hold-offs on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // compare each output transaction with the oldest prediction
    always @(posedge i_clk) begin
        ucpd_pkg::t_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (frame_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0h", $time,
                         o_out_data);
                mismatches++;
            end else begin
                want = frame_results.pop_front();
                check_field("status", 8'(want.status), 8'(o_out_data.status));
                check_field("command", want.command, o_out_data.command);
                check_field("auto_mode_flag", 8'(want.auto_mode_flag),
                            8'(o_out_data.auto_mode_flag));
                check_field("page_select", want.page_select, o_out_data.page_select);
                check_field("refresh_request", 8'(want.refresh_request),
                            8'(o_out_data.refresh_request));
                check_field("text_valid", 8'(want.text_valid), 8'(o_out_data.text_valid));
                check_field("text_line", 8'(want.text_line), 8'(o_out_data.text_line));
                check_field("text_byte", want.text_byte, o_out_data.text_byte);
                check_field("last", 8'(want.last), 8'(o_out_data.last));
            end
        end
    end

    // end the run when no transaction moves for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic offer_item(input ucpd_pkg::t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        deframe_step(it);
    endtask

    task automatic send_byte(input logic [7:0] b);
        ucpd_pkg::t_item it;
        it.kind    = ucpd_pkg::KIND_BYTE;
        it.rx_byte = b;
        offer_item(it);
    endtask

    task automatic send_tick();
        ucpd_pkg::t_item it;
        it.kind    = KIND_TICK;
        it.rx_byte = 8'($urandom_range(255));
        offer_item(it);
    endtask

    // send the first cut bytes of a frame, ticks mixed in at tick_pct
    task automatic send_frame(input logic [7:0] cmd, input int len, input bit bad_sum,
                              input int tick_pct, input int cut);
        logic [7:0] fb [ucpd_pkg::BUF_DEPTH];
        logic [7:0] sum;
        fb[0] = ucpd_pkg::SYNC0;
        fb[1] = ucpd_pkg::SYNC1;
        fb[2] = 8'(len);
        fb[3] = cmd;
        for (int i = 4; i < len - 1; i++)
            fb[i] = 8'($urandom_range(255));
        sum = 8'h00;
        for (int i = 0; i < len - 1; i++)
            sum = sum + fb[i];
        fb[len-1] = bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(99) < tick_pct)
                send_tick();
            send_byte(fb[i]);
        end
    endtask

    // feed filler bytes until the deframer holds no partial frame
    task automatic resync();
        while (frame_open || byte_count != 0)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (frame_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        timeout_ticks  = value;
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    function automatic int pick_len();
        if ($urandom_range(9) == 0)
            return $urandom_range(4, ucpd_pkg::BUF_DEPTH);
        return $urandom_range(4, 12);
    endfunction

    function automatic logic [7:0] pick_cmd();
        if ($urandom_range(99) < 85)
            return 8'($urandom_range(0, 3));
        return 8'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_commands();
        set_idling(0, 0);
        send_frame(ucpd_pkg::CMD_AUTO, 6, 1'b0, 0, 6);
        send_frame(ucpd_pkg::CMD_MANUAL, 5, 1'b0, 0, 5);
        send_frame(ucpd_pkg::CMD_TEXT1, 7, 1'b0, 0, 7);
        send_frame(ucpd_pkg::CMD_TEXT2, 6, 1'b0, 0, 6);
        // short text: no payload
        send_frame(ucpd_pkg::CMD_TEXT2, 5, 1'b0, 0, 5);
        // page taken from the sum byte
        send_frame(ucpd_pkg::CMD_AUTO, 5, 1'b0, 0, 5);
        // length 4: the command slot is the sum itself
        send_frame(ucpd_pkg::CMD_AUTO, 4, 1'b0, 0, 4);
        send_byte(ucpd_pkg::SYNC0);
        send_byte(ucpd_pkg::SYNC1);
        send_byte(8'd4);
        send_byte(ucpd_pkg::CMD_AUTO);
        send_frame(8'hFF, 6, 1'b0, 0, 6);
        send_frame(ucpd_pkg::CMD_TEXT1, 6, 1'b1, 0, 6);
    endtask

    task automatic test_header_errors();
        set_idling(28, 28);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(ucpd_pkg::SYNC0);
        send_byte(8'hFF);
        send_byte(8'd6);
        send_byte(ucpd_pkg::CMD_AUTO);
        send_frame(ucpd_pkg::CMD_MANUAL, 3, 1'b0, 0, 4);
        send_frame(ucpd_pkg::CMD_MANUAL, ucpd_pkg::BUF_DEPTH + 1, 1'b0, 0, 4);
        send_byte(ucpd_pkg::SYNC0);
        send_byte(ucpd_pkg::SYNC1);
        send_byte(8'h00);
        send_byte(ucpd_pkg::CMD_MANUAL);
        send_frame(ucpd_pkg::CMD_MANUAL, 5, 1'b0, 0, 5);
    endtask

    task automatic test_timeout();
        set_idling(0, 28);
        write_timeout(16'd2);
        // no header yet: the frame is not open and cannot time out
        send_byte(ucpd_pkg::SYNC0);
        send_byte(ucpd_pkg::SYNC1);
        send_byte(8'd8);
        repeat (4) send_tick();
        send_byte(ucpd_pkg::CMD_TEXT1);
        repeat (3) send_tick();
        write_timeout(16'd0);
        send_frame(ucpd_pkg::CMD_TEXT1, 6, 1'b0, 0, 4);
        send_tick();
        send_frame(ucpd_pkg::CMD_MANUAL, 5, 1'b0, 0, 5);
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        write_timeout(16'd1500);
        hold_requests <= hold_requests + 1;
        send_frame(ucpd_pkg::CMD_TEXT2, ucpd_pkg::BUF_DEPTH, 1'b0, 0, ucpd_pkg::BUF_DEPTH);
        send_frame(ucpd_pkg::CMD_AUTO, 6, 1'b0, 0, 6);
        repeat (4) send_tick();
        send_frame(ucpd_pkg::CMD_TEXT1, 9, 1'b0, 0, 9);
    endtask

    task automatic test_random_traffic(input int items);
        int          r;
        int          len;
        int          start;
        int          phase_items;
        logic [15:0] phase_timeout;
        phase_items = items / 4;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    phase_timeout = 16'd1;
                    set_idling(0, 0);
                end
                1: begin
                    phase_timeout = 16'd3;
                    set_idling(73, 0);
                end
                2: begin
                    phase_timeout = 16'($urandom_range(4, 60));
                    set_idling(0, 73);
                end
                default: begin
                    phase_timeout = 16'd1500;
                    set_idling(28, 28);
                end
            endcase
            write_timeout(phase_timeout);
            start = 0;
            while (start < phase_items) begin
                r = $urandom_range(99);
                if (r < 65) begin
                    resync();
                    len = pick_len();
                    send_frame(pick_cmd(), len, ($urandom_range(9) == 0),
                               ($urandom_range(1) == 0) ? 0 : 10, len);
                    start += len;
                end else if (r < 73) begin
                    resync();
                    case ($urandom_range(2))
                        0: send_byte(8'($urandom_range(255)));
                        1: send_byte(ucpd_pkg::SYNC0);
                        default: send_byte(ucpd_pkg::SYNC0);
                    endcase
                    send_byte(($urandom_range(1) == 0) ? ucpd_pkg::SYNC1
                                                       : 8'($urandom_range(255)));
                    send_byte(($urandom_range(1) == 0) ? 8'($urandom_range(0, 3))
                                                       : 8'($urandom_range(65, 255)));
                    send_byte(8'($urandom_range(255)));
                    start += 4;
                end else if (r < 81) begin
                    // frame cut off at a random point, then ticks
                    resync();
                    len = pick_len();
                    send_frame(pick_cmd(), len, 1'b0, 0, $urandom_range(4, len));
                    repeat ($urandom_range(1, 8)) send_tick();
                    start += 6;
                end else if (r < 90) begin
                    repeat ($urandom_range(1, 6)) begin
                        send_byte(8'($urandom_range(255)));
                        start++;
                    end
                end else begin
                    repeat ($urandom_range(1, 8)) begin
                        send_tick();
                        start++;
                    end
                end
            end
        end
    endtask

    initial begin
        for (int i = 0; i < ucpd_pkg::BUF_DEPTH; i++)
            frame_bytes[i] = 8'h00;
        clear_frame();
        idle_ticks    = '0;
        auto_on       = 1'b1;
        page_sel      = ucpd_pkg::PAGE_RST;
        timeout_ticks = ucpd_pkg::TIMEOUT_RST;
        mismatches    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_commands();
        test_header_errors();
        test_timeout();
        test_backpressure();
        test_random_traffic(220);

        set_idling(0, 0);
        drain();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && frame_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (frame_results.size() != 0)
                $display("%0t: %0d expected results never arrived", $time,
                         frame_results.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
